FILE: rtl/cau_pkg.sv
// Shared types, constants and the saturation helper for the complex arithmetic unit.
// Used by cau_div_step and complex_arithmetic_unit; depends on nothing else.
`default_nettype none
package cau_pkg;

  localparam int DATA_W = 32;
  localparam int FRAC_W = 16;
  localparam int LIN_W  = DATA_W + 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DEN_W  = PROD_W;
  localparam int REM_W  = DEN_W + DATA_W;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] a_re;
    logic signed [DATA_W-1:0] a_im;
    logic signed [DATA_W-1:0] b_re;
    logic signed [DATA_W-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] res_re;
    logic signed [DATA_W-1:0] res_im;
    logic                     div_zero;
    logic                     overflow;
  } rsp_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Quotient pipeline payload; non-divide results ride along in res.
  typedef struct packed {
    logic              is_div;
    logic              neg_re;
    logic              neg_im;
    logic              big_re;
    logic              big_im;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [DATA_W-1:0] q_re;
    logic [DATA_W-1:0] q_im;
    logic [DEN_W-1:0]  den;
    rsp_t              res;
  } div_bus_t;

  function automatic sat_t sat_word(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] max_v;
    logic signed [SUM_W-1:0] min_v;
    sat_t                    r;
    max_v = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    min_v = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
    if (v > max_v) begin
      r.ovf = 1'b1;
      r.val = max_v[DATA_W-1:0];
    end else if (v < min_v) begin
      r.ovf = 1'b1;
      r.val = min_v[DATA_W-1:0];
    end else begin
      r.ovf = 1'b0;
      r.val = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cau_div_step.sv
// One restoring-division stage: resolves quotient bit STEP of both parts.
// Depends on cau_pkg for the payload type.
`default_nettype none
module cau_div_step #(
  parameter int STEP = cau_pkg::DATA_W - 1
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  cau_pkg::div_bus_t      in_bus,
  output logic                   out_valid,
  input  wire                    out_ready,
  output cau_pkg::div_bus_t      out_bus
);

  logic                          valid_r;
  cau_pkg::div_bus_t             bus_r;
  cau_pkg::div_bus_t             bus_nxt;
  logic [cau_pkg::REM_W-1:0]     dsh;

  assign dsh      = cau_pkg::REM_W'(in_bus.den) << STEP;
  assign in_ready = !valid_r || out_ready;

  always_comb begin
    bus_nxt = in_bus;
    if (in_bus.rem_re >= dsh) begin
      bus_nxt.rem_re     = in_bus.rem_re - dsh;
      bus_nxt.q_re[STEP] = 1'b1;
    end
    if (in_bus.rem_im >= dsh) begin
      bus_nxt.rem_im     = in_bus.rem_im - dsh;
      bus_nxt.q_im[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      bus_r <= bus_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_bus   = bus_r;

endmodule
`default_nettype wire

FILE: rtl/complex_arithmetic_unit.sv
// Complex add, subtract, multiply and divide on signed Q16.16 parts, saturated.
// Pipeline: four front stages, one quotient bit per stage (32), one output stage.
// Throughput one request per cycle; a stalled output holds and the stall backs up stage by stage.
// Reset (rst_n low, synchronous) clears every valid bit; depends on cau_pkg and cau_div_step.
`default_nettype none
module complex_arithmetic_unit (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  cau_pkg::req_t  in_data,
  output logic           out_valid,
  input  wire            out_ready,
  output cau_pkg::rsp_t  out_data
);

  localparam int DW = cau_pkg::DATA_W;

  // Stage 1: partial products and the linear sum.
  logic                                s1_valid_r;
  logic                                s1_ready;
  logic [1:0]                          s1_op_r;
  logic signed [cau_pkg::PROD_W-1:0]   s1_ac_r, s1_bd_r, s1_ad_r, s1_bc_r, s1_cc_r, s1_dd_r;
  logic signed [cau_pkg::LIN_W-1:0]    s1_lin_re_r, s1_lin_im_r;

  // Stage 2: cross sums and denominator.
  logic                                s2_valid_r;
  logic                                s2_ready;
  logic [1:0]                          s2_op_r;
  logic signed [cau_pkg::SUM_W-1:0]    s2_sel_re_r, s2_sel_im_r;
  logic [cau_pkg::DEN_W-1:0]           s2_den_r;
  logic signed [cau_pkg::LIN_W-1:0]    s2_lin_re_r, s2_lin_im_r;

  // Stage 3: finished non-divide results, divide magnitudes.
  logic                                s3_valid_r;
  logic                                s3_ready;
  logic                                s3_is_div_r;
  logic                                s3_neg_re_r, s3_neg_im_r;
  logic [cau_pkg::SUM_W-1:0]           s3_mag_re_r, s3_mag_im_r;
  logic [cau_pkg::DEN_W-1:0]           s3_den_r;
  cau_pkg::rsp_t                       s3_res_r;
  cau_pkg::rsp_t                       s3_res_nxt;

  // Stage 4: dividend alignment and quotient range check.
  logic                                s4_valid_r;
  logic                                s4_ready;
  cau_pkg::div_bus_t                   s4_bus_r;
  cau_pkg::div_bus_t                   s4_bus_nxt;

  logic                                dv_valid [DW+1];
  logic                                dv_ready [DW+1];
  cau_pkg::div_bus_t                   dv_bus   [DW+1];

  logic                                out_valid_r;
  logic                                fin_ready;
  cau_pkg::rsp_t                       out_r;
  cau_pkg::rsp_t                       out_nxt;

  // ---------------- stage 1
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_op_r <= in_data.req_type;
      s1_ac_r <= cau_pkg::PROD_W'(in_data.a_re) * cau_pkg::PROD_W'(in_data.b_re);
      s1_bd_r <= cau_pkg::PROD_W'(in_data.a_im) * cau_pkg::PROD_W'(in_data.b_im);
      s1_ad_r <= cau_pkg::PROD_W'(in_data.a_re) * cau_pkg::PROD_W'(in_data.b_im);
      s1_bc_r <= cau_pkg::PROD_W'(in_data.a_im) * cau_pkg::PROD_W'(in_data.b_re);
      s1_cc_r <= cau_pkg::PROD_W'(in_data.b_re) * cau_pkg::PROD_W'(in_data.b_re);
      s1_dd_r <= cau_pkg::PROD_W'(in_data.b_im) * cau_pkg::PROD_W'(in_data.b_im);
      if (in_data.req_type == cau_pkg::OP_SUB) begin
        s1_lin_re_r <= cau_pkg::LIN_W'(in_data.a_re) - cau_pkg::LIN_W'(in_data.b_re);
        s1_lin_im_r <= cau_pkg::LIN_W'(in_data.a_im) - cau_pkg::LIN_W'(in_data.b_im);
      end else begin
        s1_lin_re_r <= cau_pkg::LIN_W'(in_data.a_re) + cau_pkg::LIN_W'(in_data.b_re);
        s1_lin_im_r <= cau_pkg::LIN_W'(in_data.a_im) + cau_pkg::LIN_W'(in_data.b_im);
      end
    end
  end

  // ---------------- stage 2
  assign s2_ready = !s2_valid_r || s3_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_op_r     <= s1_op_r;
      s2_lin_re_r <= s1_lin_re_r;
      s2_lin_im_r <= s1_lin_im_r;
      s2_den_r    <= s1_cc_r + s1_dd_r;
      if (s1_op_r == cau_pkg::OP_MUL) begin
        s2_sel_re_r <= cau_pkg::SUM_W'(s1_ac_r) - cau_pkg::SUM_W'(s1_bd_r);
        s2_sel_im_r <= cau_pkg::SUM_W'(s1_ad_r) + cau_pkg::SUM_W'(s1_bc_r);
      end else begin
        s2_sel_re_r <= cau_pkg::SUM_W'(s1_ac_r) + cau_pkg::SUM_W'(s1_bd_r);
        s2_sel_im_r <= cau_pkg::SUM_W'(s1_bc_r) - cau_pkg::SUM_W'(s1_ad_r);
      end
    end
  end

  // ---------------- stage 3
  logic signed [cau_pkg::SUM_W-1:0] bias_re, bias_im, mul_re, mul_im;
  cau_pkg::sat_t                    sat_re, sat_im;

  assign s3_ready = !s3_valid_r || s4_ready;

  // Negative products get a bias so the arithmetic shift truncates toward zero.
  always_comb begin
    bias_re = s2_sel_re_r[cau_pkg::SUM_W-1] ?
              cau_pkg::SUM_W'((65'd1 << cau_pkg::FRAC_W) - 65'd1) : '0;
    bias_im = s2_sel_im_r[cau_pkg::SUM_W-1] ?
              cau_pkg::SUM_W'((65'd1 << cau_pkg::FRAC_W) - 65'd1) : '0;
    mul_re  = (s2_sel_re_r + bias_re) >>> cau_pkg::FRAC_W;
    mul_im  = (s2_sel_im_r + bias_im) >>> cau_pkg::FRAC_W;
    if (s2_op_r == cau_pkg::OP_MUL) begin
      sat_re = cau_pkg::sat_word(mul_re);
      sat_im = cau_pkg::sat_word(mul_im);
    end else begin
      sat_re = cau_pkg::sat_word(cau_pkg::SUM_W'(s2_lin_re_r));
      sat_im = cau_pkg::sat_word(cau_pkg::SUM_W'(s2_lin_im_r));
    end
    s3_res_nxt.res_re   = sat_re.val;
    s3_res_nxt.res_im   = sat_im.val;
    s3_res_nxt.div_zero = 1'b0;
    s3_res_nxt.overflow = sat_re.ovf || sat_im.ovf;
    if (s2_op_r == cau_pkg::OP_DIV) begin
      s3_res_nxt.res_re   = '0;
      s3_res_nxt.res_im   = '0;
      s3_res_nxt.div_zero = (s2_den_r == '0);
      s3_res_nxt.overflow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_is_div_r <= (s2_op_r == cau_pkg::OP_DIV) && (s2_den_r != '0);
      s3_neg_re_r <= s2_sel_re_r[cau_pkg::SUM_W-1];
      s3_neg_im_r <= s2_sel_im_r[cau_pkg::SUM_W-1];
      s3_mag_re_r <= s2_sel_re_r[cau_pkg::SUM_W-1] ? -s2_sel_re_r : s2_sel_re_r;
      s3_mag_im_r <= s2_sel_im_r[cau_pkg::SUM_W-1] ? -s2_sel_im_r : s2_sel_im_r;
      s3_den_r    <= s2_den_r;
      s3_res_r    <= s3_res_nxt;
    end
  end

  // ---------------- stage 4
  logic [cau_pkg::REM_W-1:0] num_re, num_im, den_top;

  assign s4_ready = !s4_valid_r || dv_ready[0];

  // A dividend at or above den * 2^DATA_W cannot fit the quotient and saturates.
  always_comb begin
    num_re             = cau_pkg::REM_W'(s3_mag_re_r) << cau_pkg::FRAC_W;
    num_im             = cau_pkg::REM_W'(s3_mag_im_r) << cau_pkg::FRAC_W;
    den_top            = cau_pkg::REM_W'(s3_den_r) << DW;
    s4_bus_nxt.is_div  = s3_is_div_r;
    s4_bus_nxt.neg_re  = s3_neg_re_r;
    s4_bus_nxt.neg_im  = s3_neg_im_r;
    s4_bus_nxt.big_re  = (num_re >= den_top);
    s4_bus_nxt.big_im  = (num_im >= den_top);
    s4_bus_nxt.rem_re  = num_re;
    s4_bus_nxt.rem_im  = num_im;
    s4_bus_nxt.q_re    = '0;
    s4_bus_nxt.q_im    = '0;
    s4_bus_nxt.den     = s3_den_r;
    s4_bus_nxt.res     = s3_res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid_r) begin
      s4_bus_r <= s4_bus_nxt;
    end
  end

  // ---------------- quotient stages, most significant bit first
  assign dv_valid[0]  = s4_valid_r;
  assign dv_bus[0]    = s4_bus_r;
  assign dv_ready[DW] = fin_ready;

  for (genvar j = 0; j < DW; j++) begin : g_div
    cau_div_step #(
      .STEP (DW - 1 - j)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (dv_valid[j]),
      .in_ready  (dv_ready[j]),
      .in_bus    (dv_bus[j]),
      .out_valid (dv_valid[j+1]),
      .out_ready (dv_ready[j+1]),
      .out_bus   (dv_bus[j+1])
    );
  end

  // ---------------- output stage
  logic [DW-1:0] lim_re, lim_im, val_re, val_im;
  logic          ovf_re, ovf_im;

  assign fin_ready = !out_valid_r || out_ready;

  always_comb begin
    // lim is 2^(DW-1) for a negative part, 2^(DW-1)-1 otherwise.
    lim_re  = dv_bus[DW].neg_re ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    lim_im  = dv_bus[DW].neg_im ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    ovf_re  = dv_bus[DW].big_re || (dv_bus[DW].q_re > lim_re);
    ovf_im  = dv_bus[DW].big_im || (dv_bus[DW].q_im > lim_im);
    val_re  = ovf_re ? lim_re : dv_bus[DW].q_re;
    val_im  = ovf_im ? lim_im : dv_bus[DW].q_im;
    out_nxt = dv_bus[DW].res;
    if (dv_bus[DW].is_div) begin
      out_nxt.res_re   = dv_bus[DW].neg_re ? -val_re : val_re;
      out_nxt.res_im   = dv_bus[DW].neg_im ? -val_im : val_im;
      out_nxt.div_zero = 1'b0;
      out_nxt.overflow = ovf_re || ovf_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_ready) begin
      out_valid_r <= dv_valid[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (fin_ready && dv_valid[DW]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
